/* rtl/core/vau_pkg.sv */
// ---------------------------------------------------------------------------
// vau_pkg: shared types and constants for the Vicsek alignment update block
// Holds the payload structs, register indexes, sequencer states and the
// CORDIC arc table.
// ---------------------------------------------------------------------------
`default_nettype none
package vau_pkg;

    typedef struct packed {
        logic        req_type;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [15:0] heading;
        logic [15:0] noise_u;
        logic        last;
    } vau_in_t;

    typedef struct packed {
        logic [23:0] new_x;
        logic [23:0] new_y;
        logic [15:0] new_heading;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
        logic [8:0]  neighbour_count;
    } vau_out_t;

    localparam logic [1:0] REG_BOX_LENGTH  = 2'd0;
    localparam logic [1:0] REG_SPEED       = 2'd1;
    localparam logic [1:0] REG_NOISE_WIDTH = 2'd2;

    // x/y start value of a rotation, Q30
    localparam logic signed [41:0] START_GAIN = 42'sd652032875;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_ROT_INIT,
        ST_ROT_RUN,
        ST_ACCUM,
        ST_VEC_INIT,
        ST_VEC_RUN,
        ST_MOVE_INIT,
        ST_MOVE_RUN,
        ST_MOVE_MUL,
        ST_MOVE_WRAP,
        ST_OUT
    } vau_state_t;

    // CORDIC unit control bundle
    typedef struct packed {
        logic       start;
        logic       vector_mode;
        logic [4:0] steps;
    } vau_cordic_ctl_t;

    function automatic logic signed [33:0] arc_of_step(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0:  r = 34'sh020000000;
                5'd1:  r = 34'sh012E4051D;
                5'd2:  r = 34'sh009FB385B;
                5'd3:  r = 34'sh0051111D4;
                5'd4:  r = 34'sh0028B0D43;
                5'd5:  r = 34'sh00145D7E1;
                5'd6:  r = 34'sh000A2F61E;
                5'd7:  r = 34'sh000517C55;
                5'd8:  r = 34'sh00028BE53;
                5'd9:  r = 34'sh000145F2E;
                5'd10: r = 34'sh0000A2F98;
                5'd11: r = 34'sh0000517CC;
                5'd12: r = 34'sh000028BE6;
                5'd13: r = 34'sh0000145F3;
                5'd14: r = 34'sh00000A2F9;
                5'd15: r = 34'sh00000517C;
                5'd16: r = 34'sh0000028BE;
                5'd17: r = 34'sh00000145F;
                5'd18: r = 34'sh000000A2F;
                5'd19: r = 34'sh000000517;
                5'd20: r = 34'sh00000028B;
                5'd21: r = 34'sh000000145;
                5'd22: r = 34'sh0000000A2;
                5'd23: r = 34'sh000000051;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/vicsek_alignment_update_top.sv */
// ---------------------------------------------------------------------------
// vicsek_alignment_update_top: Vicsek heading and position update
// Accumulates neighbour sine/cosine sums per focal particle through a shared
// CORDIC, then forms the averaged heading plus noise and the moved position.
// ---------------------------------------------------------------------------
//  channel | direction | handshake       | word
//  in      | input     | in_valid/ready  | vau_in_t
//  out     | output    | out_valid/ready | vau_out_t
//  cfg     | input     | cfg_valid/ready | index + 24-bit data
//
//  A candidate inside the radius, while the count is below the cap, passes
//  through distance, CORDIC rotation and accumulate before the next accept;
//  one outside skips the rotation and accumulate. A last item adds a
//  vectoring pass (skipped when both sums are zero) and a second rotation,
//  both on the single shared CORDIC. in_ready is low while a word is in work;
//  a result that finds the output register still full holds the sequencer in
//  its final state. Reset restores register defaults and clears the focal state.
// ---------------------------------------------------------------------------
`default_nettype none
module vicsek_alignment_update_top #(
    parameter int MAX_CANDIDATES = 256,
    parameter int CORDIC_STEPS   = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  wire vau_pkg::vau_in_t  in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output vau_pkg::vau_out_t      out_data,
    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [1:0]              cfg_index,
    input  wire [23:0]             cfg_data
);
    import vau_pkg::*;

    localparam int CAP_I = (MAX_CANDIDATES < 511) ? MAX_CANDIDATES : 511;
    localparam logic [8:0] COUNT_CAP = 9'(CAP_I);
    localparam logic [4:0] STEPS = 5'(CORDIC_STEPS);

    vau_state_t state_reg, state_next;

    logic [23:0] box_reg;
    logic [15:0] speed_reg, noise_reg;
    logic [23:0] fx_reg, fy_reg;
    logic [15:0] fh_reg;
    logic signed [24:0] ssum_reg, csum_reg;
    logic [8:0]  cnt_reg;
    vau_in_t     item_reg;
    vau_out_t    out_reg;           // result under construction
    vau_out_t    res_reg;           // result presented on the output
    logic        out_valid_reg;
    logic        out_free;
    logic        flip_reg;
    logic signed [15:0] sin_reg, cos_reg;
    logic signed [33:0] ang_reg;
    logic        axis_reg;          // move step: 0 = x, 1 = y
    logic signed [41:0] prod_reg;
    logic signed [24:0] d_reg [2];  // may go negative for points outside the box

    vau_cordic_ctl_t    cctl;
    logic signed [41:0] cx_in, cy_in, cx, cy;
    logic signed [33:0] cz_in, cz;
    logic               cdone;

    vau_cordic u_cordic (
        .clk(clk), .rst_n(rst_n), .ctl(cctl),
        .x_in(cx_in), .y_in(cy_in), .z_in(cz_in),
        .x_out(cx), .y_out(cy), .z_out(cz), .done(cdone)
    );

    // handshake
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;
    assign out_free  = !out_valid_reg || out_ready;
    wire in_fire = in_valid && in_ready;

    // wrapped axis difference
    function automatic logic signed [24:0] axis_d(input logic [23:0] a,
                                                  input logic [23:0] b,
                                                  input logic [23:0] l);
        logic signed [25:0] d;
        begin
            d = $signed({2'b0, a}) - $signed({2'b0, b});
            if (d < 0) d = -d;
            if ((d <<< 1) > $signed({2'b0, l})) d = $signed({2'b0, l}) - d;
            return d[24:0];
        end
    endfunction

    // rounding and clamp of CORDIC x/y to Q2.14
    function automatic logic signed [15:0] q14(input logic signed [41:0] v);
        logic signed [41:0] r;
        begin
            r = (v + 42'sd32768) >>> 16;
            if (r > 42'sd16384) r = 42'sd16384;
            if (r < -42'sd16384) r = -42'sd16384;
            return r[15:0];
        end
    endfunction

    // reduce an angle to [-1/4,1/4) turn, Q32 signed z
    function automatic logic [32:0] reduce(input logic [15:0] h);
        logic [31:0] a;
        logic        f;
        begin
            a = {h, 16'd0};
            f = (a >= 32'h4000_0000) && (a < 32'hC000_0000);
            if (f) a = a - 32'h8000_0000;
            return {f, a};
        end
    endfunction

    logic [32:0] red;
    logic signed [49:0] dsq;
    logic signed [15:0] rs, rc;
    logic signed [33:0] angsum;
    logic signed [41:0] stepv;
    logic signed [25:0] npos;
    logic [23:0] pcur;

    always_comb
    begin
        red = reduce((state_reg == ST_ROT_INIT) ? item_reg.heading : fh_reg);
        dsq = 50'(d_reg[0]) * 50'(d_reg[0]) + 50'(d_reg[1]) * 50'(d_reg[1]);
        rs = flip_reg ? -q14(cy) : q14(cy);
        rc = flip_reg ? -q14(cx) : q14(cx);
        angsum = ang_reg + $signed({1'b0, item_reg.noise_u}) * 34'sd1 - 34'sd32768;
        stepv = (prod_reg + 42'sd8192) >>> 14;
        pcur = axis_reg ? fy_reg : fx_reg;
        npos = $signed({2'b0, pcur}) + stepv[25:0];
        if (npos < 0) npos = npos + $signed({2'b0, box_reg});
        if (npos > $signed({2'b0, box_reg})) npos = npos - $signed({2'b0, box_reg});
    end

    // noise product and final heading, registered into out_reg.new_heading
    logic signed [33:0] noise_prod;
    logic signed [33:0] hsum;
    assign noise_prod = (angsum - ang_reg) * $signed({18'd0, noise_reg});
    assign hsum = ang_reg + noise_prod + 34'sd32768;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_fire) state_next = ST_DIST;
            ST_DIST:      state_next = ((dsq < 50'sh1_0000_0000) && (cnt_reg < COUNT_CAP))
                                       ? ST_ROT_INIT
                                       : (item_reg.last ? ST_VEC_INIT : ST_IDLE);
            ST_ROT_INIT:  state_next = ST_ROT_RUN;
            ST_ROT_RUN:   if (cdone) state_next = ST_ACCUM;
            ST_ACCUM:     state_next = item_reg.last ? ST_VEC_INIT : ST_IDLE;
            ST_VEC_INIT:  state_next = ((ssum_reg == 0) && (csum_reg == 0))
                                       ? ST_MOVE_INIT : ST_VEC_RUN;
            ST_VEC_RUN:   if (cdone) state_next = ST_MOVE_INIT;
            ST_MOVE_INIT: state_next = ST_MOVE_RUN;
            ST_MOVE_RUN:  if (cdone) state_next = ST_MOVE_MUL;
            ST_MOVE_MUL:  state_next = ST_MOVE_WRAP;
            ST_MOVE_WRAP: state_next = axis_reg ? ST_OUT : ST_MOVE_MUL;
            ST_OUT:       state_next = out_free ? ST_IDLE : ST_OUT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // CORDIC control and operands
    always_comb
    begin
        cctl  = '{start: 1'b0, vector_mode: 1'b0, steps: STEPS};
        cx_in = START_GAIN;
        cy_in = 42'sd0;
        cz_in = $signed({1'b0, red[31:0]}) - (red[31] ? 34'sh1_0000_0000 : 34'sd0);
        case (state_reg)
            ST_ROT_INIT, ST_MOVE_INIT: cctl.start = 1'b1;
            ST_VEC_INIT:
            begin
                cctl.start = !((ssum_reg == 0) && (csum_reg == 0));
                cctl.vector_mode = 1'b1;
                cx_in = csum_reg < 0 ? -(42'(csum_reg) <<< 16) : (42'(csum_reg) <<< 16);
                cy_in = csum_reg < 0 ? -(42'(ssum_reg) <<< 16) : (42'(ssum_reg) <<< 16);
                cz_in = csum_reg < 0 ? 34'sh0_8000_0000 : 34'sd0;
            end
            default: cctl.start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            box_reg       <= 24'd458752;
            speed_reg     <= 16'd1966;
            noise_reg     <= 16'd20861;
            fx_reg <= '0; fy_reg <= '0; fh_reg <= '0;
            ssum_reg <= '0; csum_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BOX_LENGTH:  box_reg   <= cfg_data;
                    REG_SPEED:       speed_reg <= cfg_data[15:0];
                    REG_NOISE_WIDTH: noise_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_fire && !in_data.req_type)
            begin
                fx_reg <= in_data.pos_x; fy_reg <= in_data.pos_y; fh_reg <= in_data.heading;
                ssum_reg <= '0; csum_reg <= '0; cnt_reg <= '0;
            end
            if (state_reg == ST_ACCUM)
            begin
                ssum_reg <= ssum_reg + 25'(rs);
                csum_reg <= csum_reg + 25'(rc);
                cnt_reg  <= cnt_reg + 9'd1;
            end
            // output register loads once the previous word has left
            if ((state_reg == ST_OUT) && out_free) out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire) item_reg <= in_data;
        if (state_reg == ST_IDLE && in_fire)
        begin
            d_reg[0] <= axis_d(in_data.req_type ? fx_reg : in_data.pos_x, in_data.pos_x, box_reg);
            d_reg[1] <= axis_d(in_data.req_type ? fy_reg : in_data.pos_y, in_data.pos_y, box_reg);
        end
        if (state_reg == ST_ROT_INIT || state_reg == ST_MOVE_INIT) flip_reg <= red[32];
        if (state_reg == ST_VEC_INIT) ang_reg <= 34'sd0;
        if (state_reg == ST_VEC_RUN && cdone) ang_reg <= cz;
        if (state_reg == ST_MOVE_RUN && cdone)
        begin
            sin_reg  <= rs;
            cos_reg  <= rc;
            axis_reg <= 1'b0;
            out_reg.new_heading     <= hsum[31:16];
            out_reg.neighbour_count <= cnt_reg;
        end
        if (state_reg == ST_MOVE_MUL)
            prod_reg <= $signed({26'd0, speed_reg}) * (axis_reg ? sin_reg : cos_reg);
        if (state_reg == ST_MOVE_WRAP)
        begin
            if (axis_reg)
            begin
                out_reg.new_y  <= npos[23:0];
                out_reg.cell_y <= npos[23:16];
            end
            else
            begin
                out_reg.new_x  <= npos[23:0];
                out_reg.cell_x <= npos[23:16];
            end
            axis_reg <= 1'b1;
        end
        if ((state_reg == ST_OUT) && out_free) res_reg <= out_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
                     out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg == ST_OUT) |=> out_valid)
        else $error("result not raised");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= COUNT_CAP)
        else $error("count beyond cap");
endmodule
`default_nettype wire

/* rtl/core/vau_cordic.sv */
// ---------------------------------------------------------------------------
// vau_cordic: shared iterative CORDIC
// One micro-rotation per cycle, rotation mode (drive z to 0) or vectoring
// mode (drive y to 0). Operands load on start; done pulses after the last step.
// ---------------------------------------------------------------------------
`default_nettype none
module vau_cordic (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire vau_pkg::vau_cordic_ctl_t ctl,
    input  wire signed [41:0]             x_in,
    input  wire signed [41:0]             y_in,
    input  wire signed [33:0]             z_in,
    output logic signed [41:0]            x_out,
    output logic signed [41:0]            y_out,
    output logic signed [33:0]            z_out,
    output logic                          done
);
    import vau_pkg::*;

    // x/y hold the scaled sums in vectoring mode, up to about 2^41 after gain
    logic signed [41:0] x_reg, y_reg, x_next, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [4:0] i_reg, i_next, n_reg, n_next;
    logic       mode_reg, mode_next, busy_reg, busy_next, done_reg, done_next;
    logic       pos;
    logic signed [41:0] xs, ys;
    logic signed [33:0] arc;

    // one micro-rotation
    always_comb
    begin
        xs  = x_reg >>> i_reg;
        ys  = y_reg >>> i_reg;
        arc = arc_of_step(i_reg);
        pos = mode_reg ? (y_reg > 0) : (z_reg >= 0);
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; n_next = n_reg; mode_next = mode_reg;
        busy_next = busy_reg; done_next = 1'b0;
        if (ctl.start)
        begin
            x_next = x_in; y_next = y_in; z_next = z_in;
            i_next = 5'd0; n_next = ctl.steps; mode_next = ctl.vector_mode;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (pos ^ mode_reg)
            begin
                x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - arc;
            end
            else
            begin
                x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + arc;
            end
            // vectoring with y>0 rotates clockwise and adds the arc
            if (mode_reg && pos)
            begin
                x_next = x_reg + ys; y_next = y_reg - xs; z_next = z_reg + arc;
            end
            else if (mode_reg)
            begin
                x_next = x_reg - ys; y_next = y_reg + xs; z_next = z_reg - arc;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == n_reg - 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        i_reg <= i_next; n_reg <= n_next; mode_reg <= mode_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign done  = done_reg;

    // done only follows a running iteration
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy_reg))
        else $error("cordic done without busy");
    assert property (@(posedge clk) disable iff (!rst_n) ctl.start |=> busy_reg)
        else $error("cordic start did not launch");
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy_reg)
        else $error("cordic still busy at done");
endmodule
`default_nettype wire

/* sim/tb_vicsek_alignment_update_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_vicsek_alignment_update_top: self-checking bench for the Vicsek update
// Drives focal and candidate words with random bursts and gaps, predicts
// each particle result in-bench and compares it field by field.
// ---------------------------------------------------------------------------
`default_nettype none
module tb_vicsek_alignment_update_top;
    import vau_pkg::*;

    localparam int MAX_CAND    = 256;
    localparam int STEPS       = 16;
    localparam int IDLE_LIMIT  = 20000;
    localparam int LONG_SETTLE = 3 * STEPS + 40;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    vau_in_t in_data;
    logic out_valid;
    logic out_ready;
    vau_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [23:0] cfg_data;

    vicsek_alignment_update_top #(
        .MAX_CANDIDATES(MAX_CAND),
        .CORDIC_STEPS(STEPS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    longint box_len, spd, eta;
    longint fx, fy, fhead, sin_acc, cos_acc, nmatch;

    vau_in_t  pending_words[$];
    vau_out_t expected_results[$];
    int  mismatches;
    int  idle_cycles;
    bit  stim_done;
    bit  hold_sender;
    int  burst_left;
    int  gap_left;

    // Arc table, 2^32 per turn
    function automatic longint arc_step(int i);
        longint t [24] = '{
            64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
            64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
            64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
        return t[i];
    endfunction

    // >>> on longint floors for negatives
    function automatic void rotate_heading(input longint ang16, output longint s,
                                           output longint c);
        longint a, x, y, z, xs, ys;
        bit flip;
        a = (ang16 & 64'hFFFF) << 16;
        flip = 0;
        x = 652032875;
        y = 0;
        if (a >= 64'h40000000 && a < 64'hC0000000) begin
            a = (a - 64'h80000000) & 64'hFFFFFFFF;
            flip = 1;
        end
        z = (a >= 64'h80000000) ? a - 64'h100000000 : a;
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin x -= ys; y += xs; z -= arc_step(i); end
            else begin x += ys; y -= xs; z += arc_step(i); end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (x > 16384) x = 16384;
        if (x < -16384) x = -16384;
        if (y > 16384) y = 16384;
        if (y < -16384) y = -16384;
        if (flip) begin x = -x; y = -y; end
        s = y;
        c = x;
    endfunction

    function automatic longint mean_angle(longint s, longint c);
        longint x, y, z, xs, ys;
        x = c * 65536;
        y = s * 65536;
        z = 0;
        if (s == 0 && c == 0) return 0;
        if (c < 0) begin x = -x; y = -y; z = 64'h80000000; end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin x += ys; y -= xs; z += arc_step(i); end
            else begin x -= ys; y += xs; z -= arc_step(i); end
        end
        return z;
    endfunction

    function automatic longint wrapped_gap(longint a, longint b);
        longint d;
        d = a - b;
        if (d < 0) d = -d;
        if (2 * d > box_len) d = box_len - d;
        return d;
    endfunction

    function automatic longint moved_coord(longint p, longint trig);
        longint n;
        n = p + ((spd * trig + 8192) >>> 14);
        if (n < 0) n += box_len;
        if (n > box_len) n -= box_len;
        return n & 64'hFFFFFF;
    endfunction

    // Append one word to the stimulus queue
    function automatic void enqueue_word(input vau_in_t w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    // Update the particle state for one word; queue a result on last
    task automatic predict_word(input vau_in_t w);
        longint dx, dy, s, c, ang, nx, ny;
        vau_out_t r;
        if (w.req_type == 1'b0) begin
            fx = w.pos_x; fy = w.pos_y; fhead = w.heading;
            sin_acc = 0; cos_acc = 0; nmatch = 0;
        end
        dx = wrapped_gap(fx, longint'(w.pos_x));
        dy = wrapped_gap(fy, longint'(w.pos_y));
        if (dx * dx + dy * dy < 64'h100000000 && nmatch < MAX_CAND) begin
            rotate_heading(longint'(w.heading), s, c);
            sin_acc += s; cos_acc += c; nmatch++;
        end
        if (w.last) begin
            ang = mean_angle(sin_acc, cos_acc) + (longint'(w.noise_u) - 32768) * eta;
            rotate_heading(fhead, s, c);
            nx = moved_coord(fx, c);
            ny = moved_coord(fy, s);
            r.new_x = nx[23:0];
            r.new_y = ny[23:0];
            r.new_heading = 16'(((ang + 32768) >>> 16));
            r.cell_x = nx[23:16];
            r.cell_y = ny[23:16];
            r.neighbour_count = nmatch[8:0];
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    // Clock
    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // Sender: bursts and gaps, holds while paused
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 0;
            in_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) predict_word(in_data);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 0;
            end else if (pending_words.size() > 0 && !hold_sender) begin
                in_valid <= 1;
                in_data <= pending_words.pop_front();
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 0;
            end
        end
    end

    // Receiver stall pattern and result check
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected");
                    mismatches++;
                end else begin
                    vau_out_t e;
                    e = expected_results.pop_front();
                    if (out_data.new_x !== e.new_x) begin
                        $error("new_x exp %0d got %0d", e.new_x, out_data.new_x);
                        mismatches++;
                    end
                    if (out_data.new_y !== e.new_y) begin
                        $error("new_y exp %0d got %0d", e.new_y, out_data.new_y);
                        mismatches++;
                    end
                    if (out_data.new_heading !== e.new_heading) begin
                        $error("new_heading exp %0d got %0d", e.new_heading,
                               out_data.new_heading);
                        mismatches++;
                    end
                    if (out_data.cell_x !== e.cell_x) begin
                        $error("cell_x exp %0d got %0d", e.cell_x, out_data.cell_x);
                        mismatches++;
                    end
                    if (out_data.cell_y !== e.cell_y) begin
                        $error("cell_y exp %0d got %0d", e.cell_y, out_data.cell_y);
                        mismatches++;
                    end
                    if (out_data.neighbour_count !== e.neighbour_count) begin
                        $error("neighbour_count exp %0d got %0d", e.neighbour_count,
                               out_data.neighbour_count);
                        mismatches++;
                    end
                end
            end
            // stall at random, ready about seven times in ten, always ready once stimulus is done
            out_ready <= ($urandom_range(0, 9) < 7) || stim_done;
        end
    end

    // Watchdog on accepted words, results and register writes
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Queues are sampled at the falling edge, after the sender has settled
    task automatic wait_drained();
        while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (LONG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        if (idx == REG_BOX_LENGTH) box_len = val;
        else if (idx == REG_SPEED) spd = val[15:0];
        else if (idx == REG_NOISE_WIDTH) eta = val[15:0];
    endtask

    function automatic vau_in_t make_word(bit kind, longint x, longint y, bit fin);
        vau_in_t w;
        w.req_type = kind;
        w.pos_x = 24'(x);
        w.pos_y = 24'(y);
        w.heading = 16'($urandom);
        w.noise_u = 16'($urandom);
        w.last = fin;
        return w;
    endfunction

    // One particle: focal word, candidates mostly near it, last flagged
    task automatic queue_particle(input int n_cand);
        longint cx, cy, span;
        span = (box_len > 0) ? box_len : 1;
        cx = $urandom_range(0, 32'(span - 1));
        cy = $urandom_range(0, 32'(span - 1));
        enqueue_word(make_word(0, cx, cy, n_cand == 0));
        for (int k = 1; k <= n_cand; k++) begin
            longint x, y;
            if ($urandom_range(0, 9) < 7) begin
                x = cx + $urandom_range(0, 131072) - 65536;
                y = cy + $urandom_range(0, 131072) - 65536;
                if (x < 0) x += span;
                if (y < 0) y += span;
                if (x >= span) x -= span;
                if (y >= span) y -= span;
            end else if ($urandom_range(0, 4) == 0) begin
                x = $urandom & 24'hFFFFFF;
                y = $urandom & 24'hFFFFFF;
            end else begin
                x = $urandom_range(0, 32'(span - 1));
                y = $urandom_range(0, 32'(span - 1));
            end
            enqueue_word(make_word(1, x, y, k == n_cand));
        end
    endtask

    initial begin
        vau_in_t w;
        int half_mark;
        logic [23:0] boxes [4] = '{24'd65536, 24'd458752, 24'd2000000, 24'hFFFFFF};
        rst_n = 0;
        in_valid = 0;
        out_ready = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        stim_done = 0;
        hold_sender = 0;
        box_len = 458752; spd = 1966; eta = 20861;
        fx = 0; fy = 0; fhead = 0; sin_acc = 0; cos_acc = 0; nmatch = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: candidate before any focal, field extremes, zero sums
        enqueue_word(make_word(1, 0, 0, 1));
        w = make_word(0, 24'hFFFFFF, 24'hFFFFFF, 0);
        w.heading = 16'hFFFF; w.noise_u = 16'hFFFF;
        enqueue_word(w);
        w = make_word(1, 0, 0, 1);
        w.heading = 16'h0000; w.noise_u = 16'h0000;
        enqueue_word(w);
        // focal plus candidate with opposite heading: zero sums
        w = make_word(0, 65536, 65536, 0);
        w.heading = 16'h0000;
        enqueue_word(w);
        w = make_word(1, 65536, 65536, 1);
        w.heading = 16'h8000; w.noise_u = 16'h8000;
        enqueue_word(w);
        // words after last keep accumulating
        enqueue_word(make_word(1, 65600, 65700, 1));
        // wrap across the box edge, near axis headings
        w = make_word(0, 10, 458700, 0);
        w.heading = 16'h4000;
        enqueue_word(w);
        w = make_word(1, 458740, 20, 1);
        w.heading = 16'hC000;
        enqueue_word(w);
        // focal alone as last, heading at half turn
        w = make_word(0, 458752, 0, 1);
        w.heading = 16'h8000;
        enqueue_word(w);
        wait_drained();

        // Count limit: many matches on one focal
        write_reg(REG_SPEED, 24'd65535);
        enqueue_word(make_word(0, 200000, 200000, 0));
        for (int k = 0; k < 262; k++)
            enqueue_word(make_word(1, 200000 + k, 200000, k == 261));
        hold_sender = 0;
        wait_drained();

        // Random phases over several register settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_BOX_LENGTH, (ph < 4) ? boxes[ph] : 24'($urandom_range(65536, 1500000)));
            write_reg(REG_SPEED, (ph == 1) ? 24'd0 : 24'($urandom_range(0, 65535)));
            write_reg(REG_NOISE_WIDTH, (ph == 2) ? 24'd65535 :
                      (ph == 3) ? 24'd0 : 24'($urandom_range(0, 65535)));
            if (ph == 5) write_reg(REG_UNUSED, 24'($urandom));
            for (int p = 0; p < 12; p++)
                queue_particle($urandom_range(0, 18));
            if (ph == 4) begin
                // mid-phase pause until everything sent so far is back, then resume
                half_mark = pending_words.size() / 2;
                while (pending_words.size() > half_mark) @(negedge clk);
                hold_sender = 1;
                @(negedge clk);
                while (expected_results.size() > 0 || in_valid) @(negedge clk);
                hold_sender = 0;
            end
            wait_drained();
        end

        stim_done = 1;
        wait_drained();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
